// File: sv/bhs_pkg.sv
// bhs_pkg: shared types and constants of the b-h curve reluctivity block
// knot record layout, shared arithmetic unit request and word widths
// no dependencies
`default_nettype none
package bhs_pkg;

  localparam int WORD_W  = 192;
  localparam int MUL_W   = 64;
  localparam int DIV_W   = 32;
  localparam int FLUX_W  = 32;
  localparam int VAL_W   = 48;
  localparam int KNOT_W  = FLUX_W + 2 * VAL_W;

  typedef struct packed {
    logic [VAL_W-1:0]  slope;
    logic [VAL_W-1:0]  field;
    logic [FLUX_W-1:0] flux;
  } knot_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    logic    sh4;
  } alu_req_t;

endpackage
`default_nettype wire

// File: sv/bhs_ram.sv
// bhs_ram: generic single write port ram with registered read
// depends on nothing
`default_nettype none
module bhs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/bhs_alu.sv
// bhs_alu: shared shift-add multiplier and restoring divider, one bit a cycle
// signed 192-bit by 64-bit multiply-accumulate, signed 192-bit by unsigned 32-bit divide
// depends on bhs_pkg
`default_nettype none
module bhs_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bhs_pkg::alu_req_t               req,
  input  logic [bhs_pkg::WORD_W-1:0]      opa,
  input  logic [bhs_pkg::WORD_W-1:0]      opacc,
  input  logic [bhs_pkg::MUL_W-1:0]       opm,
  output logic                            busy,
  output logic                            done,
  output logic [bhs_pkg::WORD_W-1:0]      res
);
  import bhs_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} alu_state_t;

  alu_state_t        st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] p_r;
  logic [MUL_W-1:0]  m_r;
  logic [DIV_W-1:0]  d_r;
  logic [DIV_W-1:0]  rem_r;
  logic              neg_r;
  logic              done_r;

  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_dif;
  logic              ge;
  logic [WORD_W-1:0] addend;
  logic [WORD_W-1:0] mag;

  always_comb begin
    rem_sh  = {rem_r, a_r[WORD_W-1]};
    rem_dif = rem_sh - {1'b0, d_r};
    ge      = rem_sh >= {1'b0, d_r};
    if (m_r[0]) begin
      addend = (cnt_r == '0) ? (~a_r + 1'b1) : a_r;
    end else begin
      addend = '0;
    end
    mag = opa[WORD_W-1] ? (~opa + 1'b1) : opa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        A_IDLE: begin
          if (req.start) begin
            if (req.op == ALU_MUL) begin
              a_r   <= opa;
              m_r   <= opm;
              p_r   <= opacc;
              cnt_r <= CNT_W'(MUL_W - 1);
              st_r  <= A_MUL;
            end else begin
              neg_r <= opa[WORD_W-1];
              a_r   <= req.sh4 ? (mag >> 4) : mag;
              d_r   <= opm[DIV_W-1:0];
              rem_r <= '0;
              cnt_r <= CNT_W'(WORD_W - 1);
              st_r  <= A_DIV;
            end
          end
        end
        A_MUL: begin
          p_r   <= p_r + addend;
          a_r   <= a_r << 1;
          m_r   <= m_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            st_r   <= A_IDLE;
          end
        end
        A_DIV: begin
          a_r   <= {a_r[WORD_W-2:0], ge};
          rem_r <= ge ? rem_dif[DIV_W-1:0] : rem_sh[DIV_W-1:0];
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            st_r <= A_FIX;
          end
        end
        A_FIX: begin
          p_r    <= neg_r ? (~a_r + 1'b1) : a_r;
          done_r <= 1'b1;
          st_r   <= A_IDLE;
        end
        default: begin
          st_r <= A_IDLE;
        end
      endcase
    end
  end

  assign busy = (st_r != A_IDLE);
  assign done = done_r;
  assign res  = p_r;

endmodule
`default_nettype wire

// File: sv/bh_curve_spline_reluctivity.sv
// bh_curve_spline_reluctivity: knot table load and hermite reluctivity query
// a load transfer writes one knot into the ram; a query runs up to six divisions and
// up to eleven multiplies on one shared bit-serial unit, plus a segment scan over
// the knots; an empty table or zero flux answers without the shared unit
// one item at a time; the result waits in an output register
// synchronous active-low reset clears only control and cfg; the knot ram is not cleared
`default_nettype none
module bh_curve_spline_reluctivity #(
  parameter int MAX_POINTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_index, point_flux, point_field, point_slope, flux_density
  input  logic [167:0] in_tdata,
  // func
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reluctivity, reluctivity_slope
  output logic [95:0]  out_tdata,
  // saturated, no_segment
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);
  import bhs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [0:0] CFG_NUM_POINTS = 1'b0;
  localparam logic [0:0] CFG_LINEAR     = 1'b1;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic [MUL_W-1:0] ONE = 64'h0000_0001_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_RDW, S_SLOPE0, S_LASTW, S_LASTC, S_FIRSTW, S_FIRST, S_SRCHW, S_SRCH,
    S_ZDIV, S_Z2, S_Z3, S_LS0, S_LS1, S_LSL, S_H0, S_H1, S_D0, S_D1, S_G, S_GD,
    S_EXT, S_FV, S_FN, S_FD1, S_FD2, S_FD3, S_SAT, S_DONE
  } seq_state_t;

  function automatic logic [WORD_W-1:0] sx48(input logic [VAL_W-1:0] x);
    return {{(WORD_W - VAL_W){x[VAL_W-1]}}, x};
  endfunction

  seq_state_t         state_r;
  logic [5:0]         cfg_num_points_r;
  logic [VAL_W-1:0]   cfg_linear_r;
  logic [FLUX_W-1:0]  b_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      j_r;
  logic [AW-1:0]      addr_r;
  knot_t              k0_r;
  knot_t              k1_r;
  logic [32:0]        z_r;
  logic [32:0]        z2_r;
  logic [32:0]        z3_r;
  logic [WORD_W-1:0]  t_r;
  logic [WORD_W-1:0]  h_r;
  logic [WORD_W-1:0]  dh_r;
  logic [VAL_W-1:0]   rel_r;
  logic [VAL_W-1:0]   rsl_r;
  logic               sat_r;
  logic               noseg_r;
  logic               issued_r;
  logic               out_tvalid_r;
  logic [95:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;

  logic               in_acc;
  logic [FLUX_W-1:0]  raw;
  logic [FLUX_W-1:0]  bq;
  logic [CW-1:0]      n_w;
  logic               ram_we;
  logic [KNOT_W-1:0]  ram_rdata;
  knot_t              rd;
  logic [FLUX_W-1:0]  len_w;
  logic [FLUX_W-1:0]  d_w;
  logic [MUL_W-1:0]   z64, z264, z364;
  logic [MUL_W-1:0]   b00, b01, b10, b11, c0, c1, e;
  alu_req_t           alu_req;
  logic [WORD_W-1:0]  alu_a, alu_acc, alu_res;
  logic [MUL_W-1:0]   alu_m;
  logic               alu_busy, alu_done;
  logic               op_state, op_need;
  logic               rel_ok, rsl_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign raw       = in_tdata[164:133];
  assign bq        = raw[FLUX_W-1] ? (~raw + 1'b1) : raw;
  assign n_w       = (32'(cfg_num_points_r) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                          : CW'(cfg_num_points_r);
  assign ram_we    = in_acc && (in_tuser[0] == FUNC_LOAD) &&
                     (32'(in_tdata[4:0]) < MAX_POINTS);
  assign rd        = knot_t'(ram_rdata);
  assign len_w     = k1_r.flux - k0_r.flux;
  assign d_w       = b_r - k0_r.flux;

  bhs_ram #(.WIDTH(KNOT_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_tdata[4:0])),
    .wdata ({in_tdata[132:85], in_tdata[84:37], in_tdata[36:5]}),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    z64  = {31'b0, z_r};
    z264 = {31'b0, z2_r};
    z364 = {31'b0, z3_r};
    b00  = ONE - 64'd3 * z264 + 64'd2 * z364;
    b01  = 64'd3 * z264 - 64'd2 * z364;
    b10  = z64 - 64'd2 * z264 + z364;
    b11  = z364 - z264;
    c0   = ONE - 64'd4 * z64 + 64'd3 * z264;
    c1   = 64'd3 * z264 - 64'd2 * z64;
    e    = 64'd6 * (z264 - z64);
  end

  always_comb begin
    op_state    = 1'b1;
    op_need     = 1'b1;
    alu_req.op  = ALU_MUL;
    alu_req.sh4 = 1'b0;
    alu_a       = '0;
    alu_acc     = '0;
    alu_m       = '0;
    case (state_r)
      S_ZDIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = {128'b0, d_w, 32'b0};
        alu_m      = {32'b0, len_w};
        op_need    = (len_w != '0);
      end
      S_Z2: begin
        alu_a = {159'b0, z_r};
        alu_m = z64;
      end
      S_Z3: begin
        alu_a = {159'b0, z2_r};
        alu_m = z64;
      end
      S_LS0: begin
        alu_a = sx48(k0_r.slope);
        alu_m = b10;
      end
      S_LS1: begin
        alu_a   = sx48(k1_r.slope);
        alu_m   = b11;
        alu_acc = t_r;
      end
      S_LSL: begin
        alu_a = t_r;
        alu_m = {32'b0, len_w};
      end
      S_H0: begin
        alu_a   = sx48(k0_r.field);
        alu_m   = b00;
        alu_acc = t_r;
      end
      S_H1: begin
        alu_a   = sx48(k1_r.field);
        alu_m   = b01;
        alu_acc = h_r;
      end
      S_D0: begin
        alu_a = sx48(k0_r.slope);
        alu_m = c0;
      end
      S_D1: begin
        alu_a   = sx48(k1_r.slope);
        alu_m   = c1;
        alu_acc = dh_r;
      end
      S_G: begin
        alu_a = sx48(k0_r.field) - sx48(k1_r.field);
        alu_m = e;
      end
      S_GD: begin
        alu_req.op = ALU_DIV;
        alu_a      = t_r << 28;
        alu_m      = {32'b0, len_w};
      end
      S_EXT: begin
        alu_a   = sx48(k0_r.slope) << 4;
        alu_m   = {32'b0, d_w};
        alu_acc = sx48(k0_r.field) << 32;
      end
      S_FV: begin
        alu_req.op  = ALU_DIV;
        alu_req.sh4 = 1'b1;
        alu_a       = h_r;
        alu_m       = {32'b0, b_r};
      end
      S_FN: begin
        alu_a   = dh_r;
        alu_m   = {32'b0, b_r};
        alu_acc = '0 - (h_r << 28);
      end
      S_FD1: begin
        alu_req.op = ALU_DIV;
        alu_a      = dh_r << 23;
        alu_m      = {32'b0, b_r};
      end
      S_FD2, S_FD3: begin
        alu_req.op = ALU_DIV;
        alu_a      = dh_r;
        alu_m      = {32'b0, b_r};
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    alu_req.start = op_state && op_need && !issued_r;
  end

  bhs_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opacc (alu_acc),
    .opm   (alu_m),
    .busy  (alu_busy),
    .done  (alu_done),
    .res   (alu_res)
  );

  assign rel_ok = (&t_r[WORD_W-1:47]) || !(|t_r[WORD_W-1:47]);
  assign rsl_ok = (&dh_r[WORD_W-1:47]) || !(|dh_r[WORD_W-1:47]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      issued_r         <= 1'b0;
      out_tvalid_r     <= 1'b0;
      cfg_num_points_r <= '0;
      cfg_linear_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_POINTS: cfg_num_points_r <= cfg_wdata[5:0];
          CFG_LINEAR:     cfg_linear_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      if (alu_req.start) begin
        issued_r <= 1'b1;
      end
      if (alu_done) begin
        issued_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser[0] != FUNC_LOAD)) begin
            b_r     <= bq;
            n_r     <= n_w;
            rsl_r   <= '0;
            sat_r   <= 1'b0;
            noseg_r <= 1'b0;
            if (n_w == '0) begin
              rel_r   <= cfg_linear_r;
              state_r <= S_DONE;
            end else if (bq == '0) begin
              addr_r  <= '0;
              state_r <= S_RDW;
            end else begin
              addr_r  <= AW'(n_w - 1'b1);
              state_r <= S_LASTW;
            end
          end
        end
        S_RDW:    state_r <= S_SLOPE0;
        S_SLOPE0: begin
          rel_r   <= rd.slope;
          state_r <= S_DONE;
        end
        S_LASTW:  state_r <= S_LASTC;
        S_LASTC: begin
          if (b_r > rd.flux) begin
            k0_r    <= rd;
            state_r <= S_EXT;
          end else if (n_r < CW'(2)) begin
            rel_r   <= '0;
            noseg_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            addr_r  <= '0;
            state_r <= S_FIRSTW;
          end
        end
        S_FIRSTW: state_r <= S_FIRST;
        S_FIRST: begin
          k0_r    <= rd;
          j_r     <= CW'(1);
          addr_r  <= AW'(1);
          state_r <= S_SRCHW;
        end
        S_SRCHW:  state_r <= S_SRCH;
        S_SRCH: begin
          if ((k0_r.flux <= b_r) && (b_r <= rd.flux)) begin
            k1_r    <= rd;
            state_r <= S_ZDIV;
          end else begin
            k0_r <= rd;
            if (j_r == n_r - 1'b1) begin
              rel_r   <= '0;
              noseg_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              j_r     <= j_r + 1'b1;
              addr_r  <= addr_r + 1'b1;
              state_r <= S_SRCHW;
            end
          end
        end
        S_ZDIV: begin
          if (len_w == '0) begin
            z_r     <= '0;
            state_r <= S_Z2;
          end else if (alu_done) begin
            z_r     <= alu_res[32:0];
            state_r <= S_Z2;
          end
        end
        S_Z2: if (alu_done) begin
          z2_r    <= alu_res[64:32];
          state_r <= S_Z3;
        end
        S_Z3: if (alu_done) begin
          z3_r    <= alu_res[64:32];
          state_r <= S_LS0;
        end
        S_LS0: if (alu_done) begin
          t_r     <= alu_res;
          state_r <= S_LS1;
        end
        S_LS1: if (alu_done) begin
          t_r     <= alu_res;
          state_r <= S_LSL;
        end
        S_LSL: if (alu_done) begin
          t_r     <= {{28{alu_res[WORD_W-1]}}, alu_res[WORD_W-1:28]};
          state_r <= S_H0;
        end
        S_H0: if (alu_done) begin
          h_r     <= alu_res;
          state_r <= S_H1;
        end
        S_H1: if (alu_done) begin
          h_r     <= alu_res;
          state_r <= S_D0;
        end
        S_D0: if (alu_done) begin
          dh_r    <= alu_res;
          state_r <= S_D1;
        end
        S_D1: if (alu_done) begin
          dh_r    <= alu_res;
          state_r <= (len_w == '0) ? S_FV : S_G;
        end
        S_G: if (alu_done) begin
          t_r     <= alu_res;
          state_r <= S_GD;
        end
        S_GD: if (alu_done) begin
          dh_r    <= dh_r + alu_res;
          state_r <= S_FV;
        end
        S_EXT: if (alu_done) begin
          h_r     <= alu_res;
          dh_r    <= sx48(k0_r.slope) << 32;
          state_r <= S_FV;
        end
        S_FV: if (alu_done) begin
          t_r     <= alu_res;
          state_r <= S_FN;
        end
        S_FN: if (alu_done) begin
          dh_r    <= alu_res;
          state_r <= S_FD1;
        end
        S_FD1: if (alu_done) begin
          dh_r    <= alu_res;
          state_r <= S_FD2;
        end
        S_FD2: if (alu_done) begin
          dh_r    <= alu_res;
          state_r <= S_FD3;
        end
        S_FD3: if (alu_done) begin
          dh_r    <= alu_res;
          state_r <= S_SAT;
        end
        S_SAT: begin
          rel_r   <= rel_ok ? t_r[VAL_W-1:0]
                            : (t_r[WORD_W-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
          rsl_r   <= rsl_ok ? dh_r[VAL_W-1:0]
                            : (dh_r[WORD_W-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
          sat_r   <= !rel_ok || !rsl_ok;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {rsl_r, rel_r};
            out_tuser_r  <= {noseg_r, sat_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_busy)
    else $error("shared unit started while busy");

  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> issued_r)
    else $error("shared unit result without a request");

  a_noseg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0) && !out_tuser[0])
    else $error("no-segment result carries data");

endmodule
`default_nettype wire
